>>> hdl/weekly_time_window_evaluator_defines.svh
// Assertion macros used by the schedule evaluator RTL.
`ifndef WEEKLY_TIME_WINDOW_EVALUATOR_DEFINES_SVH
`define WEEKLY_TIME_WINDOW_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WTW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("schedule evaluator check failed");

// Next-cycle implication, disabled while reset is high.
`define WTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("schedule evaluator check failed");

`endif

>>> hdl/wtw_pkg.sv
package wtw_pkg;

  localparam int RULE_ENTRIES_DEFAULT = 16;

  localparam int SEC_W     = 17;
  localparam int GAP_W     = 18;
  localparam int UNTIL_W   = 20;
  localparam int WEEK_DAYS = 7;

  localparam logic [SEC_W-1:0] DAY_SECONDS = 17'd86400;
  localparam logic [SEC_W-1:0] LAST_SECOND = 17'd86399;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             is_date;
    logic [6:0]       weekdays;
    logic [13:0]      year;
    logic [3:0]       month;
    logic [4:0]       mday;
    logic [SEC_W-1:0] start_sec;
    logic [SEC_W-1:0] end_sec;
  } rule_t;

  typedef struct packed {
    logic               in_win;
    logic [GAP_W-1:0]   until_end;
    logic               found;
    logic [UNTIL_W-1:0] until_start;
  } cand_t;

  function automatic logic [SEC_W-1:0] sat_second(input logic [SEC_W-1:0] v);
    return (v > LAST_SECOND) ? LAST_SECOND : v;
  endfunction

  function automatic logic mask_has(input logic [6:0] mask, input logic [2:0] d);
    logic hit;
    hit = 1'b0;
    if (d != 3'd0) begin
      hit = mask[d - 3'd1];
    end
    return hit;
  endfunction

  // Weekday reached by stepping off days ahead; weekday zero steps as if it were seven.
  function automatic logic [2:0] next_weekday(input logic [2:0] dow, input logic [2:0] off);
    logic [4:0] s;
    s = 5'(dow) + 5'(WEEK_DAYS - 1) + 5'(off);
    if (s >= 5'(2 * WEEK_DAYS)) begin
      s = s - 5'(2 * WEEK_DAYS);
    end else if (s >= 5'(WEEK_DAYS)) begin
      s = s - 5'(WEEK_DAYS);
    end
    return 3'(s) + 3'd1;
  endfunction

  function automatic logic [UNTIL_W-1:0] day_offset(input logic [2:0] k);
    return UNTIL_W'(k) * UNTIL_W'(DAY_SECONDS);
  endfunction

endpackage

>>> hdl/wtw_rule_mem.sv
module wtw_rule_mem import wtw_pkg::*; #(
  parameter int RULE_ENTRIES = RULE_ENTRIES_DEFAULT,
  parameter int IDX_W        = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  rule_t            wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output rule_t            rd_data
);

  rule_t mem [RULE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/wtw_rule_eval.sv
module wtw_rule_eval import wtw_pkg::*; (
  input  rule_t            rule,
  input  logic [SEC_W-1:0] now,
  input  logic [SEC_W-1:0] day_left,
  input  logic [2:0]       dow,
  input  logic [13:0]      year,
  input  logic [3:0]       month,
  input  logic [4:0]       mday,
  output cand_t            cand
);

  logic               crosses;
  logic               today;
  logic               ge_start;
  logic               lt_end;
  logic [SEC_W-1:0]   start_gap;
  logic [SEC_W-1:0]   end_gap;
  logic [GAP_W-1:0]   wrap_gap;
  logic               la_hit;
  logic [2:0]         la_k;
  logic [UNTIL_W-1:0] la_gap;

  assign crosses   = rule.end_sec <= rule.start_sec;
  assign ge_start  = now >= rule.start_sec;
  assign lt_end    = now < rule.end_sec;
  assign start_gap = rule.start_sec - now;
  assign end_gap   = rule.end_sec - now;
  assign wrap_gap  = GAP_W'(day_left) + GAP_W'(rule.end_sec);
  assign today     = rule.is_date ? (rule.year == year && rule.month == month &&
                                     rule.mday == mday)
                                  : mask_has(rule.weekdays, dow);

  // First later day in the mask, nearest first.
  always_comb begin
    la_hit = 1'b0;
    la_k   = 3'd0;
    for (int k = 0; k < WEEK_DAYS; k++) begin
      if (!la_hit && mask_has(rule.weekdays, next_weekday(dow, 3'(k + 1)))) begin
        la_hit = 1'b1;
        la_k   = 3'(k);
      end
    end
  end

  assign la_gap = UNTIL_W'(day_left) + day_offset(la_k) + UNTIL_W'(rule.start_sec);

  always_comb begin
    cand = '0;
    if (today) begin
      if (crosses) begin
        if (ge_start) begin
          cand.in_win    = 1'b1;
          cand.until_end = wrap_gap;
        end else if (lt_end) begin
          cand.in_win    = 1'b1;
          cand.until_end = GAP_W'(end_gap);
        end else begin
          cand.found       = 1'b1;
          cand.until_start = UNTIL_W'(start_gap);
        end
      end else if (ge_start && lt_end) begin
        cand.in_win    = 1'b1;
        cand.until_end = GAP_W'(end_gap);
      end else if (!ge_start) begin
        cand.found       = 1'b1;
        cand.until_start = UNTIL_W'(start_gap);
      end
    end
    if (!cand.found && !rule.is_date && la_hit) begin
      cand.found       = 1'b1;
      cand.until_start = la_gap;
    end
  end

endmodule

>>> hdl/weekly_time_window_evaluator.sv
// Channel  | Handshake               | Words
// ---------+-------------------------+-------------------------------------------
// cfg      | cfg_wr_en               | cfg_wr_data = rules_in_use
// in       | in_valid / in_stall     | func, rule fields, current date and time
// out      | out_valid / out_stall   | should_track, has_transition, seconds_until_transition
//
// A rule write goes from accept straight to emit, which loads its result. An evaluate
// passes setup, one rule table read per cycle for N = min(rules_in_use, RULE_ENTRIES)
// rules, a flush to drain the read and result registers, then emit, which loads it.
// The next word can be accepted in the cycle after the load.
// in_stall is high while rst is high and from accept until the result is loaded.
// A result held by out_stall does not block the next accept, only the next result.
// rst is synchronous; the rule table is not cleared and holds garbage until written.
`include "weekly_time_window_evaluator_defines.svh"

module weekly_time_window_evaluator import wtw_pkg::*; #(
  parameter int RULE_ENTRIES = RULE_ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [3:0]         rule_index,
  input  logic               rule_is_date,
  input  logic [6:0]         rule_weekdays,
  input  logic [SEC_W-1:0]   rule_start_second,
  input  logic [SEC_W-1:0]   rule_end_second,
  input  logic [13:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day_of_month,
  input  logic [2:0]         day_of_week,
  input  logic [SEC_W-1:0]   second_of_day,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               should_track,
  output logic               has_transition,
  output logic [UNTIL_W-1:0] seconds_until_transition
);

  localparam int IDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(RULE_ENTRIES + 1);

  state_t state, state_next;

  logic [4:0]         rules_in_use;
  logic [CNT_W-1:0]   n_q;
  logic [CNT_W-1:0]   ptr;
  logic               rd_v;
  logic               cand_v;

  logic               func_q;
  logic [2:0]         dow_q;
  logic [13:0]        year_q;
  logic [3:0]         month_q;
  logic [4:0]         mday_q;
  logic [SEC_W-1:0]   now_q;
  logic [SEC_W-1:0]   day_left;

  logic               active;
  logic               have_end;
  logic               have_start;
  logic [GAP_W-1:0]   best_end;
  logic [UNTIL_W-1:0] best_start;

  logic               in_accept;
  logic               out_free;
  logic               issue;
  logic               load_out;
  logic               wr_en;
  logic [8:0]         wr_ext;
  logic [8:0]         ru_ext;
  logic [CNT_W-1:0]   n_next;
  rule_t              wr_rule;
  rule_t              rd_rule;
  cand_t              cand;
  cand_t              cand_q;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign wr_ext = {5'b0, rule_index};
  assign wr_en  = in_accept && (func == FUNC_WRITE) && (wr_ext < 9'(RULE_ENTRIES));
  assign ru_ext = {4'b0, rules_in_use};
  assign n_next = (ru_ext > 9'(RULE_ENTRIES)) ? CNT_W'(RULE_ENTRIES) : CNT_W'(ru_ext);

  always_comb begin
    wr_rule.is_date   = rule_is_date;
    wr_rule.weekdays  = rule_weekdays;
    wr_rule.year      = year;
    wr_rule.month     = month;
    wr_rule.mday      = day_of_month;
    wr_rule.start_sec = sat_second(rule_start_second);
    wr_rule.end_sec   = sat_second(rule_end_second);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (func == FUNC_EVAL) ? ST_SETUP : ST_EMIT;
        end
      end
      ST_SETUP: state_next = ST_SCAN;
      ST_SCAN: begin
        if (ptr >= n_q) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!rd_v && !cand_v) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE:  in_stall = rst;
      ST_SCAN:  issue    = ptr < n_q;
      ST_EMIT:  load_out = out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rules_in_use <= '0;
      ptr          <= '0;
      rd_v         <= 1'b0;
      cand_v       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_v   <= issue;
      cand_v <= rd_v;
      if (cfg_wr_en) begin
        rules_in_use <= cfg_wr_data;
      end
      if (state == ST_SETUP) begin
        ptr <= '0;
      end else if (issue) begin
        ptr <= ptr + CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the item, then fold one rule's candidate per cycle into the two minima.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_q  <= func;
      dow_q   <= day_of_week;
      year_q  <= year;
      month_q <= month;
      mday_q  <= day_of_month;
      now_q   <= sat_second(second_of_day);
      n_q     <= n_next;
    end
    if (rd_v) begin
      cand_q <= cand;
    end
    if (state == ST_SETUP) begin
      day_left   <= DAY_SECONDS - now_q;
      active     <= 1'b0;
      have_end   <= 1'b0;
      have_start <= 1'b0;
    end else if (cand_v) begin
      if (cand_q.in_win) begin
        active <= 1'b1;
        if (!have_end || cand_q.until_end < best_end) begin
          best_end <= cand_q.until_end;
          have_end <= 1'b1;
        end
      end
      if (cand_q.found && (!have_start || cand_q.until_start < best_start)) begin
        best_start <= cand_q.until_start;
        have_start <= 1'b1;
      end
    end
    if (load_out) begin
      if (func_q == FUNC_EVAL && active) begin
        should_track             <= 1'b1;
        has_transition           <= 1'b1;
        seconds_until_transition <= UNTIL_W'(best_end);
      end else if (func_q == FUNC_EVAL && have_start) begin
        should_track             <= 1'b0;
        has_transition           <= 1'b1;
        seconds_until_transition <= best_start;
      end else begin
        should_track             <= 1'b0;
        has_transition           <= 1'b0;
        seconds_until_transition <= '0;
      end
    end
  end

  wtw_rule_mem #(
    .RULE_ENTRIES (RULE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ext[IDX_W-1:0]),
    .wr_data (wr_rule),
    .rd_en   (issue),
    .rd_addr (ptr[IDX_W-1:0]),
    .rd_data (rd_rule)
  );

  wtw_rule_eval u_eval (
    .rule     (rd_rule),
    .now      (now_q),
    .day_left (day_left),
    .dow      (dow_q),
    .year     (year_q),
    .month    (month_q),
    .mday     (mday_q),
    .cand     (cand)
  );

  `WTW_ASSERT_NOW(a_scan_in_range, clk, rst, state == ST_SCAN, ptr <= n_q)
  `WTW_ASSERT_NOW(a_read_in_scan, clk, rst, rd_v, state == ST_SCAN || state == ST_FLUSH)
  `WTW_ASSERT_NOW(a_emit_drained, clk, rst, state == ST_EMIT, !rd_v && !cand_v)
  `WTW_ASSERT_NEXT(a_load_shows, clk, rst, load_out, out_valid && state == ST_IDLE)

endmodule

>>> verif/tb_weekly_time_window_evaluator.sv
module tb_weekly_time_window_evaluator;
  timeunit 1ns;
  timeprecision 1ps;
  import wtw_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int DAY_SEC     = 86400;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic             func;
    logic [3:0]       rule_index;
    logic             is_date;
    logic [6:0]       weekdays;
    logic [SEC_W-1:0] open_sec;
    logic [SEC_W-1:0] close_sec;
    logic [13:0]      year;
    logic [3:0]       month;
    logic [4:0]       mday;
    logic [2:0]       dow;
    logic [SEC_W-1:0] now_sec;
  } sched_word_t;

  typedef struct {
    bit        is_date;
    bit [6:0]  weekdays;
    bit [13:0] year;
    bit [3:0]  month;
    bit [4:0]  mday;
    int        open_sec;
    int        close_sec;
  } rule_entry_t;

  typedef struct {
    logic               track;
    logic               has_next;
    logic [UNTIL_W-1:0] secs;
  } verdict_t;

  class schedule_scoreboard;
    rule_entry_t rules[TABLE_DEPTH];
    int          rules_in_use;
    verdict_t    due[$];
    int          errors;

    function int clamp_second(int unsigned v);
      return (v > DAY_SEC - 1) ? DAY_SEC - 1 : int'(v);
    endfunction

    function bit day_listed(bit [6:0] days, int d);
      if (d < 1 || d > 7) return 1'b0;
      return days[d-1];
    endfunction

    function verdict_t evaluate(sched_word_t w);
      verdict_t v;
      int n, now, dow, fd, open_s, close_s;
      int until_close, until_open, best_close, best_open;
      bit today, in_win, opens, any_close, any_open, crosses;
      now = clamp_second(w.now_sec);
      dow = w.dow;
      n = (rules_in_use > TABLE_DEPTH) ? TABLE_DEPTH : rules_in_use;
      any_close = 1'b0;
      any_open = 1'b0;
      best_close = 0;
      best_open = 0;
      for (int i = 0; i < n; i++) begin
        open_s = rules[i].open_sec;
        close_s = rules[i].close_sec;
        crosses = (close_s <= open_s);
        in_win = 1'b0;
        opens = 1'b0;
        until_close = 0;
        until_open = 0;
        if (rules[i].is_date) begin
          today = (rules[i].year == w.year) && (rules[i].month == w.month) &&
                  (rules[i].mday == w.mday);
        end else begin
          today = day_listed(rules[i].weekdays, dow);
        end
        if (today) begin
          if (crosses) begin
            if (now >= open_s) begin
              in_win = 1'b1;
              until_close = DAY_SEC - now + close_s;
            end else if (now < close_s) begin
              in_win = 1'b1;
              until_close = close_s - now;
            end else begin
              opens = 1'b1;
              until_open = open_s - now;
            end
          end else if (now >= open_s && now < close_s) begin
            in_win = 1'b1;
            until_close = close_s - now;
          end else if (now < open_s) begin
            opens = 1'b1;
            until_open = open_s - now;
          end
        end
        if (in_win && (!any_close || until_close < best_close)) begin
          best_close = until_close;
          any_close = 1'b1;
        end
        // look ahead over the coming week for the next listed weekday
        if (!opens && !rules[i].is_date) begin
          for (int ahead = 1; ahead <= 7 && !opens; ahead++) begin
            fd = (dow + 6 + ahead) % 7 + 1;
            if (day_listed(rules[i].weekdays, fd)) begin
              opens = 1'b1;
              until_open = DAY_SEC - now + (ahead - 1) * DAY_SEC + open_s;
            end
          end
        end
        if (opens && (!any_open || until_open < best_open)) begin
          best_open = until_open;
          any_open = 1'b1;
        end
      end
      v.track = 1'b0;
      v.has_next = 1'b0;
      v.secs = '0;
      if (any_close) begin
        v.track = 1'b1;
        v.has_next = 1'b1;
        v.secs = UNTIL_W'(best_close);
      end else if (any_open) begin
        v.has_next = 1'b1;
        v.secs = UNTIL_W'(best_open);
      end
      return v;
    endfunction

    function void take_word(sched_word_t w);
      verdict_t v;
      v.track = 1'b0;
      v.has_next = 1'b0;
      v.secs = '0;
      if (w.func == FUNC_WRITE) begin
        rules[w.rule_index] = '{w.is_date, w.weekdays, w.year, w.month, w.mday,
                                clamp_second(w.open_sec), clamp_second(w.close_sec)};
      end else begin
        v = evaluate(w);
      end
      due = {due, v};
    endfunction

    function void report(string field, logic [UNTIL_W-1:0] want, logic [UNTIL_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual track %0d next %0d secs %0d",
                 $time, got.track, got.has_next, got.secs);
        return;
      end
      want = due.pop_front();
      if (got.track !== want.track) begin
        report("should_track", UNTIL_W'(want.track), UNTIL_W'(got.track));
      end
      if (got.has_next !== want.has_next) begin
        report("has_transition", UNTIL_W'(want.has_next), UNTIL_W'(got.has_next));
      end
      if (got.secs !== want.secs) report("seconds_until_transition", want.secs, got.secs);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [4:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall;
  logic               should_track;
  logic               has_transition;
  logic [UNTIL_W-1:0] seconds_until_transition;
  sched_word_t        in_w;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 quiet_cycles = 0;
  schedule_scoreboard sb;

  weekly_time_window_evaluator dut (
    .clk                     (clk),
    .rst                     (rst),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .func                    (in_w.func),
    .rule_index              (in_w.rule_index),
    .rule_is_date            (in_w.is_date),
    .rule_weekdays           (in_w.weekdays),
    .rule_start_second       (in_w.open_sec),
    .rule_end_second         (in_w.close_sec),
    .year                    (in_w.year),
    .month                   (in_w.month),
    .day_of_month            (in_w.mday),
    .day_of_week             (in_w.dow),
    .second_of_day           (in_w.now_sec),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .should_track            (should_track),
    .has_transition          (has_transition),
    .seconds_until_transition(seconds_until_transition)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_stall <= (int'($urandom_range(99)) < recv_idle_pct);
  end

  always @(posedge clk) begin
    verdict_t seen;
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_word(in_w);
      if (out_valid && !out_stall) begin
        seen.track = should_track;
        seen.has_next = has_transition;
        seen.secs = seconds_until_transition;
        sb.check_result(seen);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [SEC_W-1:0] pick_second();
    case ($urandom_range(19))
      0:       return '0;
      1:       return LAST_SECOND;
      2:       return SEC_W'($urandom_range(131071, 86400));
      default: return SEC_W'($urandom_range(86399));
    endcase
  endfunction

  function automatic logic [SEC_W-1:0] near_second(int s);
    int v;
    v = s + int'($urandom_range(2)) - 1;
    if (v < 0) v = 0;
    if (v > DAY_SEC - 1) v = DAY_SEC - 1;
    return SEC_W'(v);
  endfunction

  function automatic sched_word_t noise_word();
    sched_word_t w;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    w = raw[$bits(sched_word_t)-1:0];
    return w;
  endfunction

  function automatic sched_word_t mk_rule(logic [3:0] idx, logic is_date, logic [6:0] days,
                                          logic [SEC_W-1:0] open_s, logic [SEC_W-1:0] close_s,
                                          logic [13:0] y, logic [3:0] m, logic [4:0] d);
    sched_word_t w;
    w = '0;
    w.func = FUNC_WRITE;
    w.rule_index = idx;
    w.is_date = is_date;
    w.weekdays = days;
    w.open_sec = open_s;
    w.close_sec = close_s;
    w.year = y;
    w.month = m;
    w.mday = d;
    w.dow = 3'd1;
    return w;
  endfunction

  function automatic sched_word_t mk_eval(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                                          logic [2:0] dow, logic [SEC_W-1:0] now);
    sched_word_t w;
    w = '0;
    w.func = FUNC_EVAL;
    w.year = y;
    w.month = m;
    w.mday = d;
    w.dow = dow;
    w.now_sec = now;
    return w;
  endfunction

  function automatic sched_word_t rule_word(logic [3:0] idx);
    sched_word_t w;
    w = noise_word();
    w.func = FUNC_WRITE;
    w.rule_index = idx;
    w.is_date = ($urandom_range(3) == 0);
    case ($urandom_range(5))
      0:       w.weekdays = '0;
      1:       w.weekdays = '1;
      default: w.weekdays = 7'($urandom);
    endcase
    w.open_sec = pick_second();
    w.close_sec = ($urandom_range(7) == 0) ? w.open_sec : pick_second();
    w.year = $urandom_range(1) ? 14'(2000 + $urandom_range(3)) : 14'($urandom_range(9999));
    w.month = 4'($urandom_range(12));
    w.mday = 5'($urandom_range(31));
    return w;
  endfunction

  function automatic sched_word_t eval_word();
    sched_word_t w;
    rule_entry_t r;
    w = noise_word();
    w.func = FUNC_EVAL;
    r = sb.rules[$urandom_range(TABLE_DEPTH - 1)];
    // aim at a stored date half the time so date rules actually fire
    if ($urandom_range(1)) begin
      w.year = r.year;
      w.month = r.month;
      w.mday = r.mday;
    end else begin
      w.year = 14'($urandom_range(9999));
      w.month = 4'($urandom_range(12));
      w.mday = 5'($urandom_range(31));
    end
    w.dow = ($urandom_range(19) == 0) ? 3'd0 : 3'($urandom_range(7, 1));
    case ($urandom_range(9))
      0, 1:    w.now_sec = near_second(r.open_sec);
      2, 3:    w.now_sec = near_second(r.close_sec);
      default: w.now_sec = pick_second();
    endcase
    return w;
  endfunction

  task automatic send_word(input sched_word_t w);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_w <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every predicted result has been returned
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_rules_in_use(input logic [4:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.rules_in_use = v;
  endtask

  initial begin
    int phase_cfg[6];
    int phase_len[6];
    sb = new();
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_w = '0;
    out_stall = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 68;
    phase_cfg = '{16, 31, 1, 0, 0, 16};
    phase_cfg[3] = $urandom_range(15, 2);
    phase_len = '{200, 150, 100, 150, 50, 230};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table: no transition at all
    send_word(mk_eval(14'd9999, 4'd12, 5'd31, 3'd1, 17'd5000));
    send_word(mk_rule(4'd0, 1'b0, 7'b0000001, 17'd3600, 17'd7200, 14'd0, 4'd0, 5'd0));
    send_word(mk_rule(4'd1, 1'b0, 7'b1000000, 17'd79200, 17'd3600, 14'd9999, 4'd12, 5'd31));
    send_word(mk_rule(4'd2, 1'b1, 7'b0000000, 17'd0, 17'h1FFFF, 14'd9999, 4'd12, 5'd31));
    send_word(mk_rule(4'd3, 1'b1, 7'h7F, 17'd43200, 17'd43200, 14'd0, 4'd0, 5'd0));
    set_rules_in_use(5'd4);
    send_word(mk_eval(14'd9999, 4'd12, 5'd31, 3'd1, 17'd5000));
    send_word(mk_eval(14'd1, 4'd1, 5'd1, 3'd1, 17'd0));
    send_word(mk_eval(14'd1, 4'd1, 5'd1, 3'd7, 17'd80000));
    send_word(mk_eval(14'd1, 4'd1, 5'd1, 3'd7, 17'd1000));
    send_word(mk_eval(14'd1, 4'd1, 5'd1, 3'd7, 17'd5000));
    send_word(mk_eval(14'd1, 4'd1, 5'd1, 3'd0, 17'h1FFFF));
    send_word(mk_eval(14'd0, 4'd0, 5'd0, 3'd2, 17'd43200));
    send_word(mk_eval(14'd0, 4'd0, 5'd0, 3'd2, 17'd0));
    send_word(mk_eval(14'd1, 4'd1, 5'd1, 3'd6, 17'd86399));
    send_word(mk_eval(14'd9999, 4'd12, 5'd31, 3'd2, 17'd86399));
    // fill the rest of the table so any register value is safe to evaluate
    for (int i = 4; i < TABLE_DEPTH - 1; i++) send_word(rule_word(4'(i)));
    send_word(mk_rule(4'd15, 1'b1, 7'h7F, 17'h1FFFF, 17'h1FFFF, 14'd9999, 4'd12, 5'd31));

    for (int p = 0; p < 6; p++) begin
      set_rules_in_use(5'(phase_cfg[p]));
      if (p < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 68;
      end else if (p < 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < phase_len[p]; k++) begin
        if (k == phase_len[p] / 2 || $urandom_range(99) == 0) drain();
        if ($urandom_range(3) == 0) send_word(rule_word(4'($urandom_range(15))));
        else send_word(eval_word());
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/wtw_pkg.sv
hdl/wtw_rule_mem.sv
hdl/wtw_rule_eval.sv
hdl/weekly_time_window_evaluator.sv
verif/tb_weekly_time_window_evaluator.sv
